FILE: hw/rtl/clrle_pkg.sv
// Package with the shared types, constants and run flush function of the code-length RLE.
package clrle_pkg;

  localparam int CMD_DEPTH      = 4;
  localparam int ZERO_RUN_MAX   = 138;
  localparam int ZERO_LONG_MIN  = 11;
  localparam int RUN_SHORT_MIN  = 3;
  localparam int REPEAT_MAX     = 6;
  localparam int SYM_REPEAT     = 16;
  localparam int SYM_ZERO_SHORT = 17;
  localparam int SYM_ZERO_LONG  = 18;
  localparam int EBITS_REPEAT   = 2;
  localparam int EBITS_ZERO_SH  = 3;
  localparam int EBITS_ZERO_LG  = 7;

  typedef struct packed {
    logic [4:0] sym;
    logic [2:0] ebits;
    logic [6:0] eval;
  } entry_t;

  typedef struct packed {
    entry_t [2:0] slot;
    logic   [1:0] n;
    logic         fin;
  } cmd_t;

  typedef struct packed {
    entry_t     ent;
    logic [1:0] copies;
  } flush_t;

  function automatic flush_t flush_fn(input logic [3:0] value, input logic [7:0] count,
                                      input logic active);
    flush_t     res;
    logic [7:0] diff;
    res = '0;
    diff = '0;
    if (value == 4'd0) begin
      if (count >= 8'(ZERO_LONG_MIN)) begin
        diff = count - 8'(ZERO_LONG_MIN);
        res.ent = '{sym: 5'(SYM_ZERO_LONG), ebits: 3'(EBITS_ZERO_LG), eval: diff[6:0]};
        res.copies = 2'd1;
      end else if (count >= 8'(RUN_SHORT_MIN)) begin
        diff = count - 8'(RUN_SHORT_MIN);
        res.ent = '{sym: 5'(SYM_ZERO_SHORT), ebits: 3'(EBITS_ZERO_SH), eval: diff[6:0]};
        res.copies = 2'd1;
      end else begin
        res.ent = '0;
        res.copies = count[1:0];
      end
    end else begin
      if (count >= 8'(RUN_SHORT_MIN)) begin
        diff = count - 8'(RUN_SHORT_MIN);
        res.ent = '{sym: 5'(SYM_REPEAT), ebits: 3'(EBITS_REPEAT), eval: diff[6:0]};
        res.copies = 2'd1;
      end else begin
        res.ent = '{sym: {1'b0, value}, ebits: 3'd0, eval: 7'd0};
        res.copies = count[1:0];
      end
    end
    if (!active) begin
      res.copies = 2'd0;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/clrle_front.sv
// Front end: tracks the pending run and turns each code length into a command of up to three symbols.
module clrle_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [3:0]          code_length_i,
  input  logic                final_length_i,
  output logic                cmd_valid_o,
  output clrle_pkg::cmd_t     cmd_o
);

  logic [3:0] run_value_q, run_value_d;
  logic [7:0] run_count_q, run_count_d;
  logic       run_active_q, run_active_d;

  logic                 match;
  logic [7:0]           cnt_inc;
  logic                 hit;
  logic [7:0]           cnt_after;
  clrle_pkg::flush_t    flush_old;
  clrle_pkg::flush_t    flush_fin;
  clrle_pkg::entry_t    hit_ent;
  clrle_pkg::entry_t    lit_ent;
  clrle_pkg::entry_t    cand [5];
  logic [4:0]           cval;
  logic [2:0]           n;

  always_comb begin
    match   = run_active_q && (code_length_i == run_value_q);
    cnt_inc = run_count_q + 8'd1;
    if (code_length_i == 4'd0) begin
      hit     = cnt_inc >= 8'(clrle_pkg::ZERO_RUN_MAX);
      hit_ent = '{sym: 5'(clrle_pkg::SYM_ZERO_LONG), ebits: 3'(clrle_pkg::EBITS_ZERO_LG),
                  eval: 7'h7f};
    end else begin
      hit     = cnt_inc >= 8'(clrle_pkg::REPEAT_MAX);
      hit_ent = '{sym: 5'(clrle_pkg::SYM_REPEAT), ebits: 3'(clrle_pkg::EBITS_REPEAT),
                  eval: 7'd3};
    end
    lit_ent   = '{sym: {1'b0, code_length_i}, ebits: 3'd0, eval: 7'd0};
    flush_old = clrle_pkg::flush_fn(run_value_q, run_count_q, run_active_q);

    if (match) begin
      cnt_after = hit ? 8'd0 : cnt_inc;
    end else if (code_length_i != 4'd0) begin
      cnt_after = 8'd0;
    end else begin
      cnt_after = 8'd1;
    end
    flush_fin = clrle_pkg::flush_fn(code_length_i, cnt_after, final_length_i);

    if (match) begin
      cand[0] = hit_ent;
      cand[1] = hit_ent;
      cval[0] = hit;
      cval[1] = 1'b0;
      cval[2] = 1'b0;
    end else begin
      cand[0] = flush_old.ent;
      cand[1] = flush_old.ent;
      cval[0] = flush_old.copies != 2'd0;
      cval[1] = flush_old.copies == 2'd2;
      cval[2] = code_length_i != 4'd0;
    end
    cand[2] = lit_ent;
    cand[3] = flush_fin.ent;
    cand[4] = flush_fin.ent;
    cval[3] = flush_fin.copies != 2'd0;
    cval[4] = flush_fin.copies == 2'd2;

    cmd_o = '0;
    n     = 3'd0;
    for (int i = 0; i < 5; i++) begin
      if (cval[i] && (n < 3'd3)) begin
        cmd_o.slot[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    cmd_o.n     = n[1:0];
    cmd_o.fin   = final_length_i;
    cmd_valid_o = accept_i && (n != 3'd0);

    if (final_length_i) begin
      run_value_d  = 4'd0;
      run_count_d  = 8'd0;
      run_active_d = 1'b0;
    end else begin
      run_value_d  = code_length_i;
      run_count_d  = cnt_after;
      run_active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q  <= 4'd0;
      run_count_q  <= 8'd0;
      run_active_q <= 1'b0;
    end else if (accept_i) begin
      run_value_q  <= run_value_d;
      run_count_q  <= run_count_d;
      run_active_q <= run_active_d;
    end
  end

endmodule

FILE: hw/rtl/clrle_cmd_fifo.sv
// Short command queue between the front end and the symbol expander.
module clrle_cmd_fifo #(
  parameter int Depth = clrle_pkg::CMD_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  clrle_pkg::cmd_t wdata_i,
  input  logic            pop_i,
  output clrle_pkg::cmd_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  clrle_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;

endmodule

FILE: hw/rtl/clrle_back.sv
// Back end: expands queued commands into single symbols held in the output register.
module clrle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  clrle_pkg::cmd_t   cmd_i,
  output logic              cmd_pop_o,
  input  logic              pop_i,
  output logic              out_valid_o,
  output clrle_pkg::entry_t out_ent_o,
  output logic              out_last_o,
  output logic              out_end_o
);

  logic [1:0]        idx_q, idx_d;
  logic              valid_q, valid_d;
  clrle_pkg::entry_t ent_q;
  logic              last_q;
  logic              end_q;
  logic              load;
  logic              is_last;

  always_comb begin
    load      = cmd_valid_i && (!valid_q || pop_i);
    is_last   = idx_q == (cmd_i.n - 2'd1);
    cmd_pop_o = load && is_last;
    idx_d     = idx_q;
    valid_d   = valid_q;
    if (load) begin
      idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q  <= cmd_i.slot[idx_q];
      last_q <= is_last;
      end_q  <= is_last && cmd_i.fin;
    end
  end

  assign out_valid_o = valid_q;
  assign out_ent_o   = ent_q;
  assign out_last_o  = last_q;
  assign out_end_o   = end_q;

endmodule

FILE: hw/rtl/code_length_run_length_encoder.sv
// Top level of the deflate code-length run-length encoder.
// Usage: code lengths of the combined literal/length and distance sequence enter
// through a queue-like port; a length is taken at a rising edge with push high and
// full low, and final_length_i marks the last length of a sequence.
// Symbols of the code-length alphabet leave through a second queue-like port: the
// oldest symbol and its extra bits are on the outputs while empty is low, and it is
// taken at a rising edge with pop high and empty low.
// One length is taken every cycle while the command queue has room. A length that
// yields symbols places one command of up to three symbols in the queue at the edge
// that takes it; the expander drains one symbol a cycle while its output register is
// free or being popped. Lengths that only extend a run produce no symbol.
// When the receiver stalls, the output register holds its symbol, the queue of
// CMD_DEPTH commands fills and full rises; nothing is dropped.
// Reset clears the run state, empties the queue and the output register; no run is pending.
module code_length_run_length_encoder #(
  parameter int CMD_DEPTH = clrle_pkg::CMD_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [3:0] code_length_i,
  input  logic       final_length_i,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] rle_symbol_o,
  output logic [2:0] extra_bit_count_o,
  output logic [6:0] extra_value_o,
  output logic       last_for_item_o,
  output logic       sequence_end_o
);

  logic              accept;
  logic              cmd_push;
  clrle_pkg::cmd_t   cmd_in;
  clrle_pkg::cmd_t   cmd_head;
  logic              cmd_full;
  logic              cmd_empty;
  logic              cmd_pop;
  logic              out_valid;
  clrle_pkg::entry_t out_ent;

  assign accept = push && !cmd_full;
  assign full   = cmd_full;

  clrle_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .code_length_i  (code_length_i),
    .final_length_i (final_length_i),
    .cmd_valid_o    (cmd_push),
    .cmd_o          (cmd_in)
  );

  clrle_cmd_fifo #(
    .Depth (CMD_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  clrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_ent_o   (out_ent),
    .out_last_o  (last_for_item_o),
    .out_end_o   (sequence_end_o)
  );

  assign empty             = !out_valid;
  assign rle_symbol_o      = out_ent.sym;
  assign extra_bit_count_o = out_ent.ebits;
  assign extra_value_o     = out_ent.eval;

`ifndef SYNTHESIS
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("Command written into a full queue.");

  a_cmd_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_empty |-> (cmd_head.n != 2'd0))
    else $error("Queued command carries no symbol.");

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && sequence_end_o) |-> last_for_item_o)
    else $error("Sequence end shown on a symbol that is not last for its request.");

  a_pop_head_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("Command queue popped while empty.");
`endif

endmodule

FILE: test/tb_code_length_run_length_encoder.sv
// Testbench for the code-length run-length encoder, with its own symbol predictor.
module tb_code_length_run_length_encoder;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_ITEMS = 150;

  typedef enum int {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_e;

  typedef struct {
    logic [3:0] len;
    logic       fin;
    bit         drain;
  } length_req_t;

  typedef struct {
    clrle_pkg::entry_t ent;
    logic              last;
    logic              seq_end;
  } rle_due_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [3:0] code_length = 4'd0;
  logic       final_length = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [4:0] rle_symbol;
  logic [2:0] extra_bit_count;
  logic [6:0] extra_value;
  logic       last_for_item;
  logic       sequence_end;

  length_req_t       pending_lengths[$];
  rle_due_t          symbols_due[$];
  clrle_pkg::entry_t step_syms[$];
  rle_due_t          head;
  int                results_due = 0;
  int                errors = 0;
  int                cycles = 0;

  logic [3:0] run_val = 4'd0;
  logic [7:0] run_cnt = 8'd0;
  logic       run_on = 1'b0;

  int       burst_left;
  int       gap_left;
  bit       draining;
  rx_mode_e rx_mode;
  int       rx_left;

  code_length_run_length_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .code_length_i    (code_length),
    .final_length_i   (final_length),
    .empty            (empty),
    .pop              (pop),
    .rle_symbol_o     (rle_symbol),
    .extra_bit_count_o(extra_bit_count),
    .extra_value_o    (extra_value),
    .last_for_item_o  (last_for_item),
    .sequence_end_o   (sequence_end)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report(input string what);
    $display("cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic void emit(input logic [4:0] s, input logic [2:0] eb, input logic [6:0] ev);
    clrle_pkg::entry_t e;
    e.sym = s;
    e.ebits = eb;
    e.eval = ev;
    step_syms.push_back(e);
  endfunction

  function automatic void close_run();
    if (run_on) begin
      if (run_val == 4'd0) begin
        if (run_cnt >= 8'(clrle_pkg::ZERO_LONG_MIN)) begin
          emit(5'(clrle_pkg::SYM_ZERO_LONG), 3'(clrle_pkg::EBITS_ZERO_LG),
               7'(run_cnt - 8'(clrle_pkg::ZERO_LONG_MIN)));
        end else if (run_cnt >= 8'(clrle_pkg::RUN_SHORT_MIN)) begin
          emit(5'(clrle_pkg::SYM_ZERO_SHORT), 3'(clrle_pkg::EBITS_ZERO_SH),
               7'(run_cnt - 8'(clrle_pkg::RUN_SHORT_MIN)));
        end else begin
          for (int k = 0; k < int'(run_cnt); k++) emit(5'd0, 3'd0, 7'd0);
        end
      end else if (run_cnt >= 8'(clrle_pkg::RUN_SHORT_MIN)) begin
        emit(5'(clrle_pkg::SYM_REPEAT), 3'(clrle_pkg::EBITS_REPEAT),
             7'(run_cnt - 8'(clrle_pkg::RUN_SHORT_MIN)));
      end else begin
        for (int k = 0; k < int'(run_cnt); k++) emit({1'b0, run_val}, 3'd0, 7'd0);
      end
    end
    run_cnt = 8'd0;
  endfunction

  function automatic void encode_length(input logic [3:0] len, input logic fin);
    rle_due_t r;
    step_syms.delete();
    if (run_on && len == run_val) begin
      run_cnt = run_cnt + 8'd1;
      if (len == 4'd0 && run_cnt >= 8'(clrle_pkg::ZERO_RUN_MAX)) begin
        emit(5'(clrle_pkg::SYM_ZERO_LONG), 3'(clrle_pkg::EBITS_ZERO_LG),
             7'(clrle_pkg::ZERO_RUN_MAX - clrle_pkg::ZERO_LONG_MIN));
        run_cnt = 8'd0;
      end else if (len != 4'd0 && run_cnt >= 8'(clrle_pkg::REPEAT_MAX)) begin
        emit(5'(clrle_pkg::SYM_REPEAT), 3'(clrle_pkg::EBITS_REPEAT),
             7'(clrle_pkg::REPEAT_MAX - clrle_pkg::RUN_SHORT_MIN));
        run_cnt = 8'd0;
      end
    end else begin
      close_run();
      run_val = len;
      run_on = 1'b1;
      if (len != 4'd0) begin
        emit({1'b0, len}, 3'd0, 7'd0);
        run_cnt = 8'd0;
      end else begin
        run_cnt = 8'd1;
      end
    end
    if (fin) begin
      close_run();
      run_on = 1'b0;
      run_val = 4'd0;
      run_cnt = 8'd0;
    end
    foreach (step_syms[i]) begin
      r.ent = step_syms[i];
      r.last = (i == step_syms.size() - 1);
      r.seq_end = fin && (i == step_syms.size() - 1);
      symbols_due.push_back(r);
    end
  endfunction

  function automatic void queue_length(input logic [3:0] len, input logic fin);
    length_req_t q;
    q.len = len;
    q.fin = fin;
    q.drain = 1'b0;
    pending_lengths.push_back(q);
  endfunction

  // Sender: bursts of requests separated by gaps, with occasional pauses until all is drained.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      code_length <= 4'd0;
      final_length <= 1'b0;
      burst_left = 8;
      gap_left = 0;
      draining = 1'b0;
    end else begin
      if (push && !full) begin
        void'(pending_lengths.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = 60;
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      if (!(push && full)) begin
        if (draining && results_due == 0) draining = 1'b0;
        if (!draining && pending_lengths.size() > 0 && pending_lengths[0].drain) begin
          draining = 1'b1;
          pending_lengths[0].drain = 1'b0;
        end
        if (gap_left > 0 || draining || pending_lengths.size() == 0) begin
          push <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          push <= 1'b1;
          code_length <= pending_lengths[0].len;
          final_length <= pending_lengths[0].fin;
        end
      end
    end
  end

  // Receiver: stall pattern that changes to a randomly chosen mode whenever its mode counter runs out.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      rx_mode = RX_STREAM;
      rx_left = 20;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 60);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_STREAM: begin
          pop <= 1'b1;
        end
        RX_RANDOM: begin
          pop <= 1'($urandom_range(0, 1));
        end
        RX_SPARSE: begin
          pop <= ($urandom_range(0, 7) == 0);
        end
        default: begin
          pop <= (rx_left == 0);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) encode_length(code_length, final_length);
      if (pop && !empty) begin
        if (symbols_due.size() == 0) begin
          report($sformatf("unexpected symbol %0d", rle_symbol));
        end else begin
          head = symbols_due.pop_front();
          if (rle_symbol !== head.ent.sym)
            report($sformatf("symbol %0d, predicted %0d", rle_symbol, head.ent.sym));
          if (extra_bit_count !== head.ent.ebits)
            report($sformatf("extra bit count %0d, predicted %0d", extra_bit_count,
                             head.ent.ebits));
          if (extra_value !== head.ent.eval)
            report($sformatf("extra value %0d, predicted %0d", extra_value, head.ent.eval));
          if (last_for_item !== head.last)
            report($sformatf("last-for-item flag %0b, predicted %0b", last_for_item,
                             head.last));
          if (sequence_end !== head.seq_end)
            report($sformatf("sequence end flag %0b, predicted %0b", sequence_end,
                             head.seq_end));
        end
      end
      results_due <= symbols_due.size();
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int         total;
    int         runs;
    int         run_len;
    logic [3:0] v;

    queue_length(4'd0, 1'b1);
    queue_length(4'd15, 1'b1);
    queue_length(4'd0, 1'b0);
    queue_length(4'd0, 1'b1);
    repeat (3) queue_length(4'd7, 1'b0);
    queue_length(4'd7, 1'b1);
    queue_length(4'd3, 1'b0);
    queue_length(4'd3, 1'b0);
    repeat (3) queue_length(4'd0, 1'b0);
    queue_length(4'd9, 1'b1);
    repeat (3) queue_length(4'd4, 1'b0);
    queue_length(4'd0, 1'b1);
    repeat (6) queue_length(4'd5, 1'b0);
    queue_length(4'd5, 1'b1);

    // A zero run that reaches at least the maximum run length, and may leave a remainder.
    repeat (clrle_pkg::ZERO_RUN_MAX + $urandom_range(0, 20)) queue_length(4'd0, 1'b0);
    queue_length(4'd2, 1'b1);
    pending_lengths[25].drain = 1'b1;

    total = 0;
    while (total < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          queue_length(4'($urandom_range(0, 15)), ($urandom_range(0, 7) == 0));
          total++;
        end
      end else begin
        if ($urandom_range(0, 39) == 0) pending_lengths[$].drain = 1'b1;
        runs = $urandom_range(1, 8);
        for (int r = 0; r < runs; r++) begin
          v = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
          if (v == 4'd0 && $urandom_range(0, 24) == 0)
            run_len = $urandom_range(120, 160);
          else if ($urandom_range(0, 3) == 0)
            run_len = $urandom_range(6, 20);
          else
            run_len = $urandom_range(1, 6);
          repeat (run_len) queue_length(v, 1'b0);
          total += run_len;
        end
        pending_lengths[$].fin = 1'b1;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_lengths.size() != 0 || push || results_due != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (errors == 0 && symbols_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/clrle_pkg.sv
hw/rtl/clrle_front.sv
hw/rtl/clrle_cmd_fifo.sv
hw/rtl/clrle_back.sv
hw/rtl/code_length_run_length_encoder.sv
test/tb_code_length_run_length_encoder.sv
